### hdl/kli_pkg.sv
// Shared types and constants for the keyframe linear interpolator.
`default_nettype none

package kli_pkg;

    // Default table depth and the fixed fraction format of the blend factor.
    localparam int MAX_KEYS_DEF = 64;
    localparam int FRAC_BITS    = 16;
    localparam int FRAC_W       = FRAC_BITS + 1;
    localparam int VAL_W        = 32;
    localparam int KCNT_W       = 7;
    localparam int KIDX_W       = 6;
    localparam int LANES        = 3;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                   mode;
        logic [KIDX_W-1:0]       key_index;
        logic [VAL_W-1:0]        key_time;
        logic signed [VAL_W-1:0] key_x;
        logic signed [VAL_W-1:0] key_y;
        logic signed [VAL_W-1:0] key_z;
        logic [VAL_W-1:0]        query_time;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_x;
        logic signed [VAL_W-1:0] out_y;
        logic signed [VAL_W-1:0] out_z;
    } out_item_t;

    // Lane 0 is x, lane 1 is y, lane 2 is z.
    typedef logic [LANES-1:0][VAL_W-1:0] vec3_t;

    typedef struct packed {
        logic [VAL_W-1:0] key_time;
        vec3_t            val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### hdl/kli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/kli_div.sv
// Restoring divider that forms the Q1.16 segment fraction one bit per cycle.
`default_nettype none

module kli_div
    import kli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [VAL_W-1:0]  dividend,
    input  wire logic [VAL_W-1:0]  divisor,
    output logic                   done,
    output logic [FRAC_W-1:0]      quot
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [VAL_W-1:0]    rem_reg;
    logic [VAL_W-1:0]    div_reg;
    logic                zero_reg;
    logic [FRAC_W-1:0]   quot_reg;

    logic [VAL_W:0]      shifted;
    logic                ge;
    logic [VAL_W:0]      rem_next;

    // The dividend never exceeds the divisor, so the first step takes the
    // integer bit without a shift and the remainder stays below the divisor.
    always_comb begin
        shifted  = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? (shifted - {1'b0, div_reg}) : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            div_reg  <= divisor;
            zero_reg <= (divisor == '0);
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next[VAL_W-1:0];
            quot_reg <= {quot_reg[FRAC_W-2:0], ge};
        end
    end

    // A zero-length segment blends with a fraction of zero.
    assign done = done_reg;
    assign quot = zero_reg ? '0 : quot_reg;

endmodule

`default_nettype wire

### hdl/kli_blend.sv
// Shared multiplier that blends three lanes as a + floor((b - a) * t).
`default_nettype none

module kli_blend
    import kli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [FRAC_W-1:0] frac,
    input  wire vec3_t             a_val,
    input  wire vec3_t             b_val,
    output logic                   done,
    output vec3_t                  result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DIFF = 4'b0010,
        PH_MUL  = 4'b0100,
        PH_ADD  = 4'b1000
    } phase_t;

    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    phase_t                    phase_reg, phase_next;
    logic [1:0]                lane_reg;
    logic                      done_reg;
    logic [FRAC_W-1:0]         frac_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    vec3_t                     result_reg;

    logic [VAL_W-1:0]          a_sel;
    logic [VAL_W-1:0]          b_sel;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic [VAL_W-1:0]          sum_next;
    logic                      last_lane;

    always_comb begin
        a_sel     = a_val[lane_reg];
        b_sel     = b_val[lane_reg];
        diff_next = $signed({b_sel[VAL_W-1], b_sel}) - $signed({a_sel[VAL_W-1], a_sel});
        prod_next = diff_reg * $signed({1'b0, frac_reg});
        // Bits above the fraction of an arithmetic shift floor toward minus
        // infinity; the low word of that is all the sum needs.
        sum_next  = a_sel + prod_reg[FRAC_BITS +: VAL_W];
        last_lane = (lane_reg == 2'(LANES - 1));
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_DIFF;
            PH_DIFF: phase_next = PH_MUL;
            PH_MUL:  phase_next = PH_ADD;
            PH_ADD:  phase_next = last_lane ? PH_IDLE : PH_DIFF;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lane_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ADD) && last_lane;
            if (phase_reg == PH_IDLE) begin
                lane_reg <= '0;
            end else if (phase_reg == PH_ADD) begin
                lane_reg <= last_lane ? 2'd0 : lane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_IDLE && start) begin
            frac_reg <= frac;
        end
        if (phase_reg == PH_DIFF) begin
            diff_reg <= diff_next;
        end
        if (phase_reg == PH_MUL) begin
            prod_reg <= prod_next;
        end
        if (phase_reg == PH_ADD) begin
            result_reg[lane_reg] <= sum_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/keyframe_linear_interpolator_top.sv
// Top level of the keyframe linear interpolator: control sequencer and ports.
`default_nettype none

// The block keeps up to MAX_KEYS keyframes (a Q16.16 time and x, y, z values)
// in one synchronous table memory and answers queries by linear
// interpolation between the two keys that bracket the query time. A load
// transfer (mode 0) writes one entry in the cycle it is accepted and yields
// no result; entries at or beyond MAX_KEYS are dropped. A query transfer
// (mode 1) yields one result transfer. The table has a single read port, so
// a query walks the stored keys one per cycle. A query at or before the
// first key, or past the last key, then goes straight to the output
// register. A query that falls inside a segment then passes through the
// bit-serial fraction divider and the shared multiplier that blends x, y
// and z in turn. The idle state accepts each query and the output state
// hands its result to the output register. The number of valid keys is set
// through cfg_we and cfg_wdata; the user must write it only while the block
// is idle, as the block does not enforce this. Zero is treated as one and
// values above MAX_KEYS as MAX_KEYS. Every entry that a query can reach must
// have been loaded first, since the table is not cleared at reset. While a
// result waits in the output register the block still accepts load transfers
// and starts the next query.
module keyframe_linear_interpolator_top
    import kli_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              cfg_we,
    input  wire logic [KCNT_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_KEYS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_BLEND = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [KCNT_W-1:0]  key_count_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      last_idx_reg;
    logic [VAL_W-1:0]   q_reg;
    entry_t             prev_reg;
    vec3_t              seg_b_reg;
    vec3_t              res_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic               in_accept;
    logic               out_free;
    logic [31:0]        cnt_ext;
    logic [31:0]        n_sat;
    logic [31:0]        last_full;
    logic [31:0]        widx_ext;
    logic               load_in_range;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    entry_t             ram_wdata;
    entry_t             cur;

    logic               first_key;
    logic               emit;
    logic               seg_found;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  frac;
    logic               blend_start;
    logic               blend_done;
    vec3_t              blend_res;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // Effective key count, clamped to the range one to MAX_KEYS.
    always_comb begin
        cnt_ext = 32'(key_count_reg);
        if (cnt_ext == '0) begin
            n_sat = 32'd1;
        end else if (cnt_ext > 32'(MAX_KEYS)) begin
            n_sat = 32'(MAX_KEYS);
        end else begin
            n_sat = cnt_ext;
        end
        last_full = n_sat - 32'd1;
    end

    // Loads are written in the cycle they are accepted.
    always_comb begin
        widx_ext           = 32'(s_data.key_index);
        load_in_range      = widx_ext < 32'(MAX_KEYS);
        ram_we             = in_accept && (s_data.mode == MODE_LOAD) && load_in_range;
        ram_wdata.key_time = s_data.key_time;
        ram_wdata.val[0]   = s_data.key_x;
        ram_wdata.val[1]   = s_data.key_y;
        ram_wdata.val[2]   = s_data.key_z;
    end

    kli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (cur)
    );

    // In the walk the read data belongs to entry idx_reg and prev_reg holds
    // the entry before it. The first segment that brackets the query wins.
    always_comb begin
        state_next  = state_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        emit        = 1'b0;
        seg_found   = 1'b0;
        div_start   = 1'b0;
        blend_start = 1'b0;
        first_key   = (idx_reg == '0);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_data.mode == MODE_QUERY) begin
                    ram_re     = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (first_key) begin
                    emit = (last_idx_reg == '0) || (q_reg <= cur.key_time);
                end else if (prev_reg.key_time <= q_reg && q_reg <= cur.key_time) begin
                    seg_found = 1'b1;
                end else begin
                    emit = (idx_reg == last_idx_reg);
                end
                if (emit) begin
                    state_next = ST_OUT;
                end else if (seg_found) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    blend_start = 1'b1;
                    state_next  = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (blend_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    kli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (q_reg - prev_reg.key_time),
        .divisor  (cur.key_time - prev_reg.key_time),
        .done     (div_done),
        .quot     (frac)
    );

    kli_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blend_start),
        .frac    (frac),
        .a_val   (prev_reg.val),
        .b_val   (seg_b_reg),
        .done    (blend_done),
        .result  (blend_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_count_reg <= KCNT_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                key_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_accept) begin
            idx_reg      <= '0;
            last_idx_reg <= last_full[AW-1:0];
            q_reg        <= s_data.query_time;
        end
        if (state_reg == ST_WALK && !emit && !seg_found) begin
            idx_reg  <= idx_reg + AW'(1);
            prev_reg <= cur;
        end
        if (seg_found) begin
            seg_b_reg <= cur.val;
        end
        if (emit) begin
            res_reg <= cur.val;
        end else if (blend_done) begin
            res_reg <= blend_res;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.out_x <= res_reg[0];
            m_data_reg.out_y <= res_reg[1];
            m_data_reg.out_z <= res_reg[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The walk never reads past the last valid key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= last_idx_reg))
        else $error("walk index passed the last key");

    // A query starts its walk at the first entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_data.mode == MODE_QUERY) |=> (state_reg == ST_WALK && idx_reg == '0))
        else $error("query did not start its walk at entry zero");

    // A load finishes in the cycle it is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_data.mode == MODE_LOAD) |=> (state_reg == ST_IDLE))
        else $error("load left the idle state");

    // The fraction never exceeds one, since the query lies inside the segment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (frac <= FRAC_W'(1 << FRAC_BITS)))
        else $error("segment fraction above one");

    // The blend unit only reports completion while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        blend_done |-> (state_reg == ST_BLEND))
        else $error("blend finished outside the blend state");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the keyframe linear interpolator top level.
`timescale 1ns / 1ps

module tb_top;
    import kli_pkg::*;

    // The table depth of the block under test. The instance keeps its default.
    localparam int TABLE_DEPTH = MAX_KEYS_DEF;
    // The longest query walks every key, divides and blends. A load gives no
    // result, so before a register write and at the end we let this many cycles
    // pass once nothing is pending.
    localparam int DRAIN_CYCLES = 128;
    // The watchdog fires after this many cycles in a row without any transfer.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1050;
    localparam int MAX_REPORTS = 10;

    // Receiver stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              cfg_we = 1'b0;
    logic [KCNT_W-1:0] cfg_wdata = '0;

    // Our own copy of the keyframe table and of the key count register. The
    // table is filled as load transfers are accepted, so it always matches the
    // block's contents at the moment a query transfer is accepted.
    logic [VAL_W-1:0]  key_times [TABLE_DEPTH];
    out_item_t         key_values [TABLE_DEPTH];
    logic [KCNT_W-1:0] key_count_reg = 7'd1;

    // Interpolated points that the block still owes us, oldest first.
    out_item_t predicted_points [$];
    out_item_t oldest_point;

    int error_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;
    logic [3:0] rx_phase = '0;

    keyframe_linear_interpolator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // One lane of the blend: a + floor((b - a) * frac / 65536). The difference
    // needs 33 bits and the product at most 50, so 64-bit math is exact, and an
    // arithmetic shift of the signed product is the floor toward minus infinity.
    function automatic logic [VAL_W-1:0] blend_lane(logic signed [VAL_W-1:0] a,
                                                    logic signed [VAL_W-1:0] b,
                                                    logic [FRAC_W-1:0] frac);
        longint la;
        longint diff;
        longint prod;
        longint blended;
        la = longint'(a);
        diff = longint'(b) - la;
        prod = diff * longint'({47'd0, frac});
        blended = la + (prod >>> FRAC_BITS);
        return blended[VAL_W-1:0];
    endfunction

    // Works out the point that a query at time q must return, given the table
    // and key count as they stand now.
    function automatic out_item_t interpolate_point(logic [VAL_W-1:0] q);
        int n;
        int sel;
        int i;
        bit found;
        logic [VAL_W-1:0] t0;
        logic [VAL_W-1:0] t1;
        logic [VAL_W-1:0] span;
        logic [63:0] ratio;
        logic [FRAC_W-1:0] frac;
        out_item_t point;
        // A count of zero acts as one and a count above the depth saturates.
        if (key_count_reg == '0) begin
            n = 1;
        end else if (int'(key_count_reg) > TABLE_DEPTH) begin
            n = TABLE_DEPTH;
        end else begin
            n = int'(key_count_reg);
        end
        found = 1'b0;
        point = '0;
        // A single key, or a time at or before the first key, gives the first
        // key. Otherwise the first segment in index order that holds q wins,
        // and if none does the last key is returned.
        sel = (n == 1 || q <= key_times[0]) ? 0 : n - 1;
        if (sel != 0) begin
            for (i = 0; i < n - 1 && !found; i++) begin
                t0 = key_times[i];
                t1 = key_times[i + 1];
                if (t0 <= q && q <= t1) begin
                    found = 1'b1;
                    span = t1 - t0;
                    // A zero-length segment gives a fraction of zero.
                    frac = '0;
                    if (span != '0) begin
                        ratio = {32'd0, q - t0} << FRAC_BITS;
                        ratio = ratio / {32'd0, span};
                        frac = ratio[FRAC_W-1:0];
                    end
                    point.out_x = blend_lane(key_values[i].out_x, key_values[i + 1].out_x, frac);
                    point.out_y = blend_lane(key_values[i].out_y, key_values[i + 1].out_y, frac);
                    point.out_z = blend_lane(key_values[i].out_z, key_values[i + 1].out_z, frac);
                end
            end
        end
        if (!found) begin
            point = key_values[sel];
        end
        return point;
    endfunction

    // An item with every field random; the fields that the mode does not use
    // stay random so that the block is seen to ignore them.
    function automatic in_item_t random_item(mode_t m);
        in_item_t it;
        it.mode = m;
        it.key_index = KIDX_W'($urandom);
        it.key_time = $urandom;
        it.key_x = $urandom;
        it.key_y = $urandom;
        it.key_z = $urandom;
        it.query_time = $urandom;
        return it;
    endfunction

    // Keyframe values lean on the extremes, where b - a overflows 32 bits.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7FFF_FFFF;
            end
            2: begin
                return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Presents one item and holds it until the transfer happens. The sender
    // runs in bursts of random length; before each burst it may drop valid for
    // a random gap. Valid is never lowered between items of one burst. When
    // the transfer is seen, a load updates our table and a query queues the
    // point it must produce.
    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (item.mode == MODE_LOAD) begin
            key_times[item.key_index] = item.key_time;
            key_values[item.key_index] = '{item.key_x, item.key_y, item.key_z};
        end else begin
            predicted_points.insert(predicted_points.size(),
                                    interpolate_point(item.query_time));
        end
        items_sent++;
    endtask

    task automatic load_key(input logic [KIDX_W-1:0] idx, input logic [VAL_W-1:0] t,
                            input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                            input logic [VAL_W-1:0] z);
        in_item_t item;
        item = random_item(MODE_LOAD);
        item.key_index = idx;
        item.key_time = t;
        item.key_x = x;
        item.key_y = y;
        item.key_z = z;
        send_item(item);
    endtask

    task automatic query_at(input logic [VAL_W-1:0] q);
        in_item_t item;
        item = random_item(MODE_QUERY);
        item.query_time = q;
        send_item(item);
    endtask

    // Stops sending, waits for every owed result, then lets a last query or
    // load finish inside the block.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (predicted_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The key count may only change while the block is idle.
    task automatic set_key_count(input logic [KCNT_W-1:0] count);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we <= 1'b0;
        key_count_reg = count;
    endtask

    // With one key every query returns that key, whatever its time. The load
    // to the highest index writes the top entry.
    task automatic test_single_key();
        set_key_count(7'd1);
        load_key(6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
        load_key(6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // A key count of zero behaves as one.
    task automatic test_zero_count();
        set_key_count(7'd0);
        query_at(32'h0005_0000);
        query_at(32'h0000_0000);
    endtask

    // Four keys with a zero-length segment in the middle. The queries hit the
    // first key, the inside and both ends of a segment, and the very last time.
    task automatic test_segment_walk();
        set_key_count(7'd4);
        load_key(6'd1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
        load_key(6'd2, 32'h0003_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        load_key(6'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000);
        query_at(32'h0001_0000);
        query_at(32'h0001_0001);
        query_at(32'h0002_0000);
        query_at(32'h0002_FFFF);
        query_at(32'h0003_0000);
        query_at(32'h8000_0000);
        query_at(32'hFFFF_FFFF);
    endtask

    // Key 1 now lies before key 0, so the first segment can hold nothing: a
    // query past key 0 walks on to the second one, and one before key 0 gives key 0.
    task automatic test_unordered_times();
        load_key(6'd1, 32'h0000_8000, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000);
        query_at(32'h0002_0000);
        query_at(32'h0000_C000);
    endtask

    // Random phases: each one sets a key count, loads a fresh table for it and
    // then queries it. The first phases take the count extremes. Most tables
    // are small and ascending, some are large, some are unordered, and a few
    // stray loads to random entries are mixed in among the queries.
    task automatic test_random_tables();
        logic [VAL_W-1:0] phase_times [TABLE_DEPTH];
        logic [KCNT_W-1:0] count;
        logic [32:0] acc;
        logic [VAL_W-1:0] q;
        int first_item;
        int phase;
        int n;
        int i;
        int j;
        int seg;
        int query_count;
        bit unordered;
        first_item = items_sent;
        phase = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            case (phase)
                0: count = 7'd127;
                1: count = 7'd64;
                2: count = 7'd65;
                3: count = 7'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: count = KCNT_W'($urandom_range(9, 127));
                        1: count = KCNT_W'($urandom_range(0, 1));
                        default: count = KCNT_W'($urandom_range(2, 8));
                    endcase
                end
            endcase
            set_key_count(count);
            if (count == '0) begin
                n = 1;
            end else if (int'(count) > TABLE_DEPTH) begin
                n = TABLE_DEPTH;
            end else begin
                n = int'(count);
            end

            // Every entry a query can reach is loaded before the first query.
            unordered = ($urandom_range(0, 9) == 0);
            acc = ($urandom_range(0, 3) == 0) ? 33'd0 : 33'($urandom_range(0, 32'h0100_0000));
            for (i = 0; i < n; i++) begin
                if (unordered) begin
                    phase_times[i] = $urandom_range(0, 32'h000F_FFFF);
                end else begin
                    phase_times[i] = acc[VAL_W-1:0];
                    case ($urandom_range(0, 7))
                        0: acc = acc;
                        1: acc = acc + 33'($urandom_range(0, 32'h0800_0000));
                        default: acc = acc + 33'($urandom_range(1, 32'h0004_0000));
                    endcase
                    if (acc > 33'h0_FFFF_FFFF) begin
                        acc = 33'h0_FFFF_FFFF;
                    end
                end
                load_key(KIDX_W'(i), phase_times[i], pick_value(), pick_value(), pick_value());
            end

            query_count = $urandom_range(8, 40);
            for (j = 0; j < query_count; j++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(random_item(MODE_LOAD));
                end else begin
                    case ($urandom_range(0, 9))
                        0: q = $urandom_range(0, phase_times[0]);
                        1: q = $urandom_range(phase_times[n - 1], 32'hFFFF_FFFF);
                        2: q = phase_times[$urandom_range(0, n - 1)];
                        3: q = $urandom;
                        default: begin
                            if (n > 1) begin
                                seg = $urandom_range(0, n - 2);
                                q = $urandom_range(phase_times[seg], phase_times[seg + 1]);
                            end else begin
                                q = $urandom;
                            end
                        end
                    endcase
                    query_at(q);
                end
            end
            phase++;
        end
    endtask

    // The receiver switches at random between stall patterns: always ready,
    // ready half the time, mostly stalled, and a fixed pattern of equal runs
    // of ready and stalled cycles.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 400);
        end
        rx_left--;
        rx_phase = rx_phase + 4'd1;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 5) == 0);
            default: m_ready <= rx_phase[2];
        endcase
    end

    // Every result transfer is compared with the oldest owed point. Signals
    // are read right after the edge, before any register in the design or in
    // this testbench takes its new value, so they hold what the edge sampled.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (predicted_points.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("result with no query pending: x=%h y=%h z=%h",
                             m_data.out_x, m_data.out_y, m_data.out_z);
                end
            end else begin
                oldest_point = predicted_points.pop_front();
                if (m_data.out_x !== oldest_point.out_x || m_data.out_y !== oldest_point.out_y ||
                    m_data.out_z !== oldest_point.out_z) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("point mismatch: x exp %h got %h, y exp %h got %h, z exp %h got %h",
                                 oldest_point.out_x, m_data.out_x, oldest_point.out_y,
                                 m_data.out_y, oldest_point.out_z, m_data.out_z);
                    end
                end
            end
        end
    end

    // The run is stuck if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset is held once at the start; then the tests run in turn and the
    // verdict is printed once everything owed has arrived.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_key();
        test_zero_count();
        test_segment_walk();
        test_unordered_times();
        test_random_tables();
        wait_for_results();
        if (error_count == 0 && predicted_points.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
